// ===== rtl/core/wfsa_pkg.sv =====
// Shared types and constants for the wraparound-free server assigner.
// No dependencies; compiled first.
`default_nettype none

package wfsa_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int ECNT_W      = $clog2(MAX_RESULTS);
    localparam int TIME_W      = 31;
    localparam int BUSY_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 5;
    localparam int OIDX_W      = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_ASSIGN = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_BUSY   = 2'd2,
        KIND_NONE   = 2'd3
    } wfsa_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PICK,
        ST_COMMIT,
        ST_RPT_LOAD,
        ST_RPT_SCAN
    } wfsa_state_t;

    typedef struct packed {
        logic commit;
        logic capture;
        logic shift;
    } wfsa_cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/wfsa_if.sv =====
// Channel interfaces: configuration write, job/report request, result.
// No dependencies.
`default_nettype none

interface wfsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] active_servers;

    modport source (output valid, output active_servers, input ready);
    modport sink   (input valid, input active_servers, output ready);
endinterface

interface wfsa_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [30:0] arrival_time;
    logic [30:0] job_duration;

    modport source (output valid, output mode, output arrival_time, output job_duration,
                    input ready);
    modport sink   (input valid, input mode, input arrival_time, input job_duration,
                    output ready);
endinterface

interface wfsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  server_index;
    logic [15:0] served_count;
    logic        last_result;

    modport source (output valid, output kind, output server_index, output served_count,
                    output last_result, input ready);
    modport sink   (input valid, input kind, input server_index, input served_count,
                    input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wfsa_cell.sv =====
// One server cell: busy-until time, served count and report hit bit.
// Depends on wfsa_pkg.
`default_nettype none

module wfsa_cell
    import wfsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TIME_W-1:0]   arrival,
    input  logic [TIME_W-1:0]   duration,
    input  logic [COUNT_W-1:0]  best,
    input  wfsa_cell_cmd_t      cmd,
    input  logic                grant,
    input  logic                hit_in,
    output logic                free,
    output logic [COUNT_W-1:0]  count,
    output logic                hit
);

    logic [BUSY_W-1:0]  busy_reg;
    logic [BUSY_W-1:0]  busy_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               hit_reg;
    logic               hit_next;

    assign free  = busy_reg <= {1'b0, arrival};
    assign count = count_reg;
    assign hit   = hit_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        hit_next   = hit_reg;
        if (cmd.commit && grant)
        begin
            busy_next = {1'b0, arrival} + {1'b0, duration};
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        if (cmd.capture)
        begin
            hit_next = (count_reg == best);
        end
        else if (cmd.shift)
        begin
            hit_next = hit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wraparound_free_server_assigner_core.sv =====
// Busiest-server job assigner: top level with control sequencer and row of server cells.
// Depends on wfsa_pkg, wfsa_if, wfsa_cell.
//
// Usage:
//   cfg : write of active_servers (0 acts as 1, above SERVERS acts as SERVERS); always ready,
//         it is to be written only while the block is idle; the block does not enforce this.
//   req : mode 0 is a job (arrival_time, job_duration), mode 1 asks for a busiest report.
//   rsp : result items; last_result marks the final item of each request.
// Sequence:
//   A job passes through search, wraparound pick and commit, then the block returns to idle
//   and accepts the next request; its result is registered at commit. When active_servers
//   was lowered to or below the stored request number, search first repeatedly subtracts
//   the active count from it until it is below. A report captures the hit bits, then
//   shifts them down the cell row one server per cycle, holding at a hit while rsp is full.
//   One result waits in the output register while the next request is accepted.
// Reset: all servers free, counts and best count zero, request number zero, 16 active.
// Stall: when rsp is not taken, the sequencer holds before writing the next result;
//   cells neither commit nor shift past a hit until the output register frees up.
`default_nettype none

module wraparound_free_server_assigner_core
    import wfsa_pkg::*;
#(
    parameter int SERVERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    wfsa_cfg_if.sink    cfg,
    wfsa_req_if.sink    req,
    wfsa_rsp_if.source  rsp
);

    localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int AW = IW + 1;

    wfsa_state_t         state_reg, state_next;
    logic [CFG_W-1:0]    act_cfg_reg;
    logic [IW-1:0]       rn_reg, rn_next;
    logic [TIME_W-1:0]   arr_reg, arr_next;
    logic [TIME_W-1:0]   dur_reg, dur_next;
    logic [SERVERS-1:0]  free_reg, free_next;
    logic [SERVERS-1:0]  grant_reg, grant_next;
    logic [COUNT_W-1:0]  best_reg, best_next;
    logic [IW-1:0]       sidx_reg, sidx_next;
    logic [ECNT_W-1:0]   ecnt_reg, ecnt_next;

    logic                rsp_valid_reg, rsp_valid_next;
    wfsa_kind_t          rsp_kind_reg, rsp_kind_next;
    logic [OIDX_W-1:0]   rsp_idx_reg, rsp_idx_next;
    logic [COUNT_W-1:0]  rsp_cnt_reg, rsp_cnt_next;
    logic                rsp_last_reg, rsp_last_next;

    logic [AW-1:0]       act;
    logic [SERVERS-1:0]  act_mask;
    logic [SERVERS-1:0]  cell_free;
    logic [SERVERS-1:0]  cell_hit;
    logic [COUNT_W-1:0]  cell_cnt [SERVERS];
    wfsa_cell_cmd_t      cmd;
    logic                out_free;

    assign cfg.ready        = 1'b1;
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.kind         = rsp_kind_reg;
    assign rsp.server_index = rsp_idx_reg;
    assign rsp.served_count = rsp_cnt_reg;
    assign rsp.last_result  = rsp_last_reg;

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        logic [6:0] a_ext;
        a_ext = {2'b00, act_cfg_reg};
        if (a_ext == 7'd0)
        begin
            act = AW'(1);
        end
        else if (a_ext > 7'(SERVERS))
        begin
            act = AW'(SERVERS);
        end
        else
        begin
            act = AW'(a_ext);
        end
        for (int i = 0; i < SERVERS; i++)
        begin
            act_mask[i] = (AW'(i) < act);
        end
    end

    for (genvar g = 0; g < SERVERS; g++)
    begin : g_cell
        logic hit_in;
        if (g == SERVERS - 1)
        begin : g_tail
            assign hit_in = 1'b0;
        end
        else
        begin : g_link
            assign hit_in = cell_hit[g+1];
        end

        wfsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .arrival  (arr_reg),
            .duration (dur_reg),
            .best     (best_reg),
            .cmd      (cmd),
            .grant    (grant_reg[g]),
            .hit_in   (hit_in),
            .free     (cell_free[g]),
            .count    (cell_cnt[g]),
            .hit      (cell_hit[g])
        );
    end

    always_comb
    begin
        logic [SERVERS-1:0]  lo_mask;
        logic [SERVERS-1:0]  hi_free;
        logic [SERVERS-1:0]  src;
        logic [AW-1:0]       start_inc;
        logic [IW-1:0]       gidx;
        logic [IW+3:0]       wide_idx;
        logic [COUNT_W-1:0]  sel_cnt;
        logic [COUNT_W-1:0]  new_cnt;
        logic                more_hits;

        state_next     = state_reg;
        rn_next        = rn_reg;
        arr_next       = arr_reg;
        dur_next       = dur_reg;
        free_next      = free_reg;
        grant_next     = grant_reg;
        best_next      = best_reg;
        sidx_next      = sidx_reg;
        ecnt_next      = ecnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_kind_next  = rsp_kind_reg;
        rsp_idx_next   = rsp_idx_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        rsp_last_next  = rsp_last_reg;
        cmd            = '0;

        for (int i = 0; i < SERVERS; i++)
        begin
            lo_mask[i] = (IW'(i) < rn_reg);
        end
        hi_free   = free_reg & ~lo_mask;
        src       = (hi_free != '0) ? hi_free : free_reg;
        start_inc = {1'b0, rn_reg} + AW'(1);

        gidx    = '0;
        sel_cnt = '0;
        for (int i = 0; i < SERVERS; i++)
        begin
            if (grant_reg[i])
            begin
                gidx    = gidx | IW'(i);
                sel_cnt = sel_cnt | cell_cnt[i];
            end
        end
        new_cnt   = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + COUNT_W'(1);
        more_hits = (cell_hit >> 1) != '0;
        wide_idx  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    arr_next = req.arrival_time;
                    dur_next = req.job_duration;
                    if (req.mode)
                    begin
                        state_next = ST_RPT_LOAD;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // bring a stale request number back under the active count
                if ({1'b0, rn_reg} >= act)
                begin
                    rn_next = IW'({1'b0, rn_reg} - act);
                end
                else
                begin
                    free_next  = cell_free & act_mask;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                grant_next = src & (~src + SERVERS'(1));
                rn_next    = (start_inc == act) ? '0 : IW'(start_inc);
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_last_next  = 1'b1;
                    if (grant_reg != '0)
                    begin
                        cmd.commit    = 1'b1;
                        wide_idx      = {4'b0000, gidx};
                        rsp_kind_next = KIND_ASSIGN;
                        rsp_idx_next  = wide_idx[OIDX_W-1:0];
                        rsp_cnt_next  = new_cnt;
                        if (new_cnt > best_reg)
                        begin
                            best_next = new_cnt;
                        end
                    end
                    else
                    begin
                        rsp_kind_next = KIND_DROP;
                        rsp_idx_next  = '0;
                        rsp_cnt_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RPT_LOAD:
            begin
                if (best_reg == '0)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_kind_next  = KIND_NONE;
                        rsp_idx_next   = '0;
                        rsp_cnt_next   = '0;
                        rsp_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.capture = 1'b1;
                    sidx_next   = '0;
                    ecnt_next   = '0;
                    state_next  = ST_RPT_SCAN;
                end
            end
            ST_RPT_SCAN:
            begin
                if (cell_hit[0])
                begin
                    if (out_free)
                    begin
                        wide_idx       = {4'b0000, sidx_reg};
                        rsp_valid_next = 1'b1;
                        rsp_kind_next  = KIND_BUSY;
                        rsp_idx_next   = wide_idx[OIDX_W-1:0];
                        rsp_cnt_next   = best_reg;
                        rsp_last_next  = !more_hits || (ecnt_reg == ECNT_W'(MAX_RESULTS - 1));
                        cmd.shift      = 1'b1;
                        sidx_next      = sidx_reg + IW'(1);
                        ecnt_next      = ecnt_reg + ECNT_W'(1);
                        if (rsp_last_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.shift = 1'b1;
                    sidx_next = sidx_reg + IW'(1);
                    if (sidx_reg == IW'(SERVERS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_cfg_reg   <= ACTIVE_RESET;
            rn_reg        <= '0;
            best_reg      <= '0;
            sidx_reg      <= '0;
            ecnt_reg      <= '0;
            grant_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rn_reg        <= rn_next;
            best_reg      <= best_next;
            sidx_reg      <= sidx_next;
            ecnt_reg      <= ecnt_next;
            grant_reg     <= grant_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                act_cfg_reg <= cfg.active_servers;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg      <= arr_next;
        dur_reg      <= dur_next;
        free_reg     <= free_next;
        rsp_kind_reg <= rsp_kind_next;
        rsp_idx_reg  <= rsp_idx_next;
        rsp_cnt_reg  <= rsp_cnt_next;
        rsp_last_reg <= rsp_last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/wfsa_chk.sv =====
// Port-level checker for the server assigner, bound to the top level.
// Depends on wfsa_pkg and the top level's ports.
`default_nettype none

module wfsa_chk
    import wfsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_kind,
    input logic [3:0]  rsp_server_index,
    input logic [15:0] rsp_served_count,
    input logic        rsp_last_result
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_DROP || rsp_kind == KIND_NONE)
        |-> rsp_server_index == '0 && rsp_served_count == '0 && rsp_last_result)
        else $error("dropped or empty report item malformed");

    a_assign_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == KIND_ASSIGN |-> rsp_served_count != '0 && rsp_last_result)
        else $error("assigned item malformed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

endmodule

bind wraparound_free_server_assigner_core wfsa_chk u_wfsa_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_kind         (rsp.kind),
    .rsp_server_index (rsp.server_index),
    .rsp_served_count (rsp.served_count),
    .rsp_last_result  (rsp.last_result)
);

`default_nettype wire
